[hw/rtl/pbrq_pkg.sv]
// Shared types and constants of the PCM block ring queue.
package pbrq_pkg;

    // Build defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF        = 16;
    localparam int MAX_BLOCK_SAMPLES_DEF = 64;
    localparam int META_BITS_DEF         = 32;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int SEQ_W    = 32;
    localparam int META_W   = 32;
    localparam int CAP_CFG_W = 5;
    localparam int CNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Saturation point of the push sample counter
    localparam logic [CNT_W-1:0] PUSH_COUNT_SAT = 7'd127;

    // Configuration reset values
    localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd16;
    localparam logic [CNT_W-1:0]     BS_RESET  = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SAMPLES = 2'd1;

    // Input item kinds
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_PEEK = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;

    // Result item kinds
    localparam logic [1:0] RK_PUSH   = 2'd0;
    localparam logic [1:0] RK_SAMPLE = 2'd1;
    localparam logic [1:0] RK_EMPTY  = 2'd2;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_PEEK
    } state_t;

endpackage

[hw/rtl/pcm_block_ring_queue.sv]
// PCM block ring queue: staging buffer, sample store, slot table and control sequencer.
// Push: a push sample without last gives no result; a closing push gives its status item
//   from the output register in the cycle after acceptance, and an accepted block then blocks
//   input while the staging memory is copied into the sample store.
// Throughput: a peek streams its clamped block size of items at 1 per cycle while the result
//   channel is not stalled, bounded by the single read port of the sample store; pop gives no result.
// Reset: pointers, counters and sequences clear and config registers load their defaults at
//   once; memory contents are left undefined and need no clearing pass.
module pcm_block_ring_queue
#(
    parameter int MAX_BLOCKS        = pbrq_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_BLOCK_SAMPLES = pbrq_pkg::MAX_BLOCK_SAMPLES_DEF,
    parameter int META_BITS         = pbrq_pkg::META_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pbrq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pbrq_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            kind,
    input  logic signed [pbrq_pkg::SAMPLE_W-1:0]  sample,
    input  logic [pbrq_pkg::META_W-1:0]           metadata,
    input  logic                                  last,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            result_kind,
    output logic [pbrq_pkg::SEQ_W-1:0]            sequence_res,
    output logic                                  accepted,
    output logic [pbrq_pkg::META_W-1:0]           block_metadata,
    output logic signed [pbrq_pkg::SAMPLE_W-1:0]  out_sample,
    output logic                                  run_end,
    output logic [pbrq_pkg::SEQ_W-1:0]            done_sequence
);
    import pbrq_pkg::*;

    localparam int SLOT_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IDX_W  = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1;
    localparam int OCC_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CAP_W  = (OCC_W > CAP_CFG_W) ? OCC_W : CAP_CFG_W;
    localparam int MW     = (META_BITS < META_W) ? META_BITS : META_W;
    localparam int INFO_W = SEQ_W + MW;
    localparam int STORE_DEPTH = MAX_BLOCKS * (2 ** IDX_W);
    localparam int ADDR_W = SLOT_W + IDX_W;

    // Memories
    logic [SAMPLE_W-1:0] staging_mem [0:MAX_BLOCK_SAMPLES-1];
    logic [SAMPLE_W-1:0] store_mem   [0:STORE_DEPTH-1];
    logic [INFO_W-1:0]   info_mem    [0:MAX_BLOCKS-1];

    // Configuration registers
    logic [CAP_CFG_W-1:0] capacity_reg;
    logic [CNT_W-1:0]     block_samples_reg;

    // Control state
    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [OCC_W-1:0]  occupancy_reg, occupancy_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]  completed_seq_reg, completed_seq_next;
    logic [CNT_W-1:0]  push_count_reg, push_count_next;

    // Copy sequencer
    logic [SLOT_W-1:0] copy_slot_reg, copy_slot_next;
    logic [CNT_W-1:0]  copy_len_reg, copy_len_next;
    logic [CNT_W-1:0]  copy_cnt_reg, copy_cnt_next;
    logic              wr_valid_reg, wr_valid_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [SAMPLE_W-1:0] stg_rdata_reg;
    logic              stg_re;
    logic              stg_we;

    // Peek sequencer
    logic [SLOT_W-1:0] peek_slot_reg, peek_slot_next;
    logic [CNT_W-1:0]  peek_len_reg, peek_len_next;
    logic [CNT_W-1:0]  peek_cnt_reg, peek_cnt_next;
    logic              rd_pending_reg, rd_pending_next;
    logic              rd_end_reg, rd_end_next;
    logic [SAMPLE_W-1:0] store_rdata_reg;
    logic [INFO_W-1:0]   info_rdata_reg;
    logic              store_re;
    logic              info_re;
    logic              info_we;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          result_kind_reg, result_kind_next;
    logic [SEQ_W-1:0]    sequence_res_reg, sequence_res_next;
    logic                accepted_reg, accepted_next;
    logic [META_W-1:0]   block_metadata_reg, block_metadata_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                run_end_reg, run_end_next;
    logic [SEQ_W-1:0]    done_sequence_reg, done_sequence_next;

    // Derived controls
    logic             can_load;
    logic             in_acc;
    logic [CAP_W-1:0] eff_cap;
    logic [CNT_W-1:0] count_now;
    logic             bs_ok;
    logic             push_ok;
    logic [CNT_W-1:0] peek_n;

    // Step a slot index, wrapping at the effective capacity
    function automatic logic [SLOT_W-1:0] adv_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CAP_W-1:0]  cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(s) + CAP_W'(1);
        return (n >= cap) ? '0 : n[SLOT_W-1:0];
    endfunction

    // Clamp capacity and block size, evaluate the push verdict
    always_comb
    begin
        if (capacity_reg == '0)
            eff_cap = CAP_W'(1);
        else if (CAP_W'(capacity_reg) > CAP_W'(MAX_BLOCKS))
            eff_cap = CAP_W'(MAX_BLOCKS);
        else
            eff_cap = CAP_W'(capacity_reg);

        if (block_samples_reg == '0)
            peek_n = CNT_W'(1);
        else if (block_samples_reg > CNT_W'(MAX_BLOCK_SAMPLES))
            peek_n = CNT_W'(MAX_BLOCK_SAMPLES);
        else
            peek_n = block_samples_reg;

        count_now = (push_count_reg == PUSH_COUNT_SAT) ? PUSH_COUNT_SAT
                                                       : push_count_reg + CNT_W'(1);
        bs_ok   = (block_samples_reg != '0) &&
                  (block_samples_reg <= CNT_W'(MAX_BLOCK_SAMPLES));
        push_ok = bs_ok && (count_now == block_samples_reg) &&
                  (CAP_W'(occupancy_reg) < eff_cap);
    end

    assign can_load  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && can_load);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Next state, memory strobes and result register loads
    always_comb
    begin
        state_next         = state_reg;
        write_slot_next    = write_slot_reg;
        read_slot_next     = read_slot_reg;
        occupancy_next     = occupancy_reg;
        next_seq_next      = next_seq_reg;
        completed_seq_next = completed_seq_reg;
        push_count_next    = push_count_reg;
        copy_slot_next     = copy_slot_reg;
        copy_len_next      = copy_len_reg;
        copy_cnt_next      = copy_cnt_reg;
        wr_valid_next      = 1'b0;
        wr_idx_next        = wr_idx_reg;
        peek_slot_next     = peek_slot_reg;
        peek_len_next      = peek_len_reg;
        peek_cnt_next      = peek_cnt_reg;
        rd_pending_next    = rd_pending_reg;
        rd_end_next        = rd_end_reg;
        stg_re             = 1'b0;
        stg_we             = 1'b0;
        store_re           = 1'b0;
        info_re            = 1'b0;
        info_we            = 1'b0;

        // drop the held item once taken
        out_valid_next      = out_valid_reg && out_stall;
        result_kind_next    = result_kind_reg;
        sequence_res_next   = sequence_res_reg;
        accepted_next       = accepted_reg;
        block_metadata_next = block_metadata_reg;
        out_sample_next     = out_sample_reg;
        run_end_next        = run_end_reg;
        done_sequence_next  = done_sequence_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (kind)
                        KIND_PUSH:
                        begin
                            stg_we          = (push_count_reg < CNT_W'(MAX_BLOCK_SAMPLES));
                            push_count_next = count_now;
                            if (last)
                            begin
                                push_count_next    = '0;
                                next_seq_next      = next_seq_reg + SEQ_W'(1);
                                completed_seq_next = next_seq_reg + SEQ_W'(1);
                                if (push_ok)
                                begin
                                    info_we         = 1'b1;
                                    copy_slot_next  = write_slot_reg;
                                    copy_len_next   = count_now;
                                    copy_cnt_next   = '0;
                                    write_slot_next = adv_slot(write_slot_reg, eff_cap);
                                    occupancy_next  = occupancy_reg + OCC_W'(1);
                                    state_next      = S_COPY;
                                end
                                out_valid_next      = 1'b1;
                                result_kind_next    = RK_PUSH;
                                sequence_res_next   = next_seq_reg;
                                accepted_next       = push_ok;
                                block_metadata_next = '0;
                                out_sample_next     = '0;
                                run_end_next        = 1'b1;
                                done_sequence_next  = next_seq_reg + SEQ_W'(1);
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (occupancy_reg == '0)
                            begin
                                out_valid_next      = 1'b1;
                                result_kind_next    = RK_EMPTY;
                                sequence_res_next   = '0;
                                accepted_next       = 1'b0;
                                block_metadata_next = '0;
                                out_sample_next     = '0;
                                run_end_next        = 1'b1;
                                done_sequence_next  = completed_seq_reg;
                            end
                            else
                            begin
                                info_re         = 1'b1;
                                peek_slot_next  = read_slot_reg;
                                peek_len_next   = peek_n;
                                peek_cnt_next   = '0;
                                rd_pending_next = 1'b0;
                                state_next      = S_PEEK;
                            end
                        end
                        KIND_POP:
                        begin
                            if (occupancy_reg != '0)
                            begin
                                read_slot_next = adv_slot(read_slot_reg, eff_cap);
                                occupancy_next = occupancy_reg - OCC_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                // read staging one entry a cycle, write it to the store in the following cycle
                if (copy_cnt_reg < copy_len_reg)
                begin
                    stg_re        = 1'b1;
                    wr_valid_next = 1'b1;
                    wr_idx_next   = copy_cnt_reg[IDX_W-1:0];
                    copy_cnt_next = copy_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PEEK:
            begin
                // hand the pending read to the output register
                if (rd_pending_reg && can_load)
                begin
                    out_valid_next      = 1'b1;
                    result_kind_next    = RK_SAMPLE;
                    sequence_res_next   = info_rdata_reg[MW +: SEQ_W];
                    accepted_next       = 1'b0;
                    block_metadata_next = META_W'(info_rdata_reg[MW-1:0]);
                    out_sample_next     = store_rdata_reg;
                    run_end_next        = rd_end_reg;
                    done_sequence_next  = completed_seq_reg;
                    rd_pending_next     = 1'b0;
                    if (rd_end_reg)
                        state_next = S_IDLE;
                end
                // issue the next sample read while the read register frees up
                if ((peek_cnt_reg < peek_len_reg) && (!rd_pending_reg || can_load))
                begin
                    store_re        = 1'b1;
                    rd_pending_next = 1'b1;
                    rd_end_next     = ((peek_cnt_reg + CNT_W'(1)) == peek_len_reg);
                    peek_cnt_next   = peek_cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold config registers, pointers, counters and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg      <= CAP_RESET;
            block_samples_reg <= BS_RESET;
            write_slot_reg    <= '0;
            read_slot_reg     <= '0;
            occupancy_reg     <= '0;
            next_seq_reg      <= '0;
            completed_seq_reg <= '0;
            push_count_reg    <= '0;
            copy_cnt_reg      <= '0;
            copy_len_reg      <= '0;
            wr_valid_reg      <= 1'b0;
            peek_cnt_reg      <= '0;
            peek_len_reg      <= '0;
            rd_pending_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAPACITY:      capacity_reg      <= cfg_data[CAP_CFG_W-1:0];
                    CFG_BLOCK_SAMPLES: block_samples_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            write_slot_reg    <= write_slot_next;
            read_slot_reg     <= read_slot_next;
            occupancy_reg     <= occupancy_next;
            next_seq_reg      <= next_seq_next;
            completed_seq_reg <= completed_seq_next;
            push_count_reg    <= push_count_next;
            copy_cnt_reg      <= copy_cnt_next;
            copy_len_reg      <= copy_len_next;
            wr_valid_reg      <= wr_valid_next;
            peek_cnt_reg      <= peek_cnt_next;
            peek_len_reg      <= peek_len_next;
            rd_pending_reg    <= rd_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        copy_slot_reg      <= copy_slot_next;
        wr_idx_reg         <= wr_idx_next;
        peek_slot_reg      <= peek_slot_next;
        rd_end_reg         <= rd_end_next;
        result_kind_reg    <= result_kind_next;
        sequence_res_reg   <= sequence_res_next;
        accepted_reg       <= accepted_next;
        block_metadata_reg <= block_metadata_next;
        out_sample_reg     <= out_sample_next;
        run_end_reg        <= run_end_next;
        done_sequence_reg  <= done_sequence_next;
    end

    // Staging memory: write open push samples, read during the copy
    always_ff @(posedge clk)
    begin
        if (stg_we)
            staging_mem[push_count_reg[IDX_W-1:0]] <= sample;
        if (stg_re)
            stg_rdata_reg <= staging_mem[copy_cnt_reg[IDX_W-1:0]];
    end

    // Sample store: copy writes, peek reads
    always_ff @(posedge clk)
    begin
        if (wr_valid_reg)
            store_mem[ADDR_W'({copy_slot_reg, wr_idx_reg})] <= stg_rdata_reg;
        if (store_re)
            store_rdata_reg <= store_mem[ADDR_W'({peek_slot_reg, peek_cnt_reg[IDX_W-1:0]})];
    end

    // Slot table: sequence and metadata per block
    always_ff @(posedge clk)
    begin
        if (info_we)
            info_mem[write_slot_reg] <= {next_seq_reg, metadata[MW-1:0]};
        if (info_re)
            info_rdata_reg <= info_mem[read_slot_reg];
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = result_kind_reg;
    assign sequence_res   = sequence_res_reg;
    assign accepted       = accepted_reg;
    assign block_metadata = block_metadata_reg;
    assign out_sample     = $signed(out_sample_reg);
    assign run_end        = run_end_reg;
    assign done_sequence  = done_sequence_reg;

    // Occupancy never exceeds the built depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= OCC_W'(MAX_BLOCKS))
        else $error("occupancy above built depth");

    // A peek read is only pending inside the peek run
    a_rd_in_peek: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> (state_reg == S_PEEK))
        else $error("peek read pending outside peek");

    // A peek run only starts on a non-empty queue
    a_peek_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PEEK) |-> (occupancy_reg != '0))
        else $error("peek run on empty queue");

    // A stored block raises occupancy by one
    a_push_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (kind == KIND_PUSH) && last && push_ok)
        |=> (occupancy_reg == $past(occupancy_reg) + OCC_W'(1)))
        else $error("stored block did not raise occupancy");

    // Store writes only come from the copy
    a_copy_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (state_reg == S_COPY))
        else $error("store write outside copy");

endmodule

[dv/pcm_block_ring_queue_test.sv]
// Self-checking testbench for the PCM block ring queue: directed table, then random phases.
module pcm_block_ring_queue_test;
    import pbrq_pkg::*;

    localparam int NSLOT = MAX_BLOCKS_DEF;
    localparam int MAXS = MAX_BLOCK_SAMPLES_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // cycles to let a block copy finish before a register write or the end
    localparam int COPY_SETTLE = 80;
    localparam int STALL_LIMIT = 3000;
    localparam int NPHASE = 8;

    typedef struct packed {
        logic [1:0]  rkind;
        logic [31:0] seq;
        logic        acc;
        logic [31:0] meta;
        logic [15:0] smp;
        logic        fin;
        logic [31:0] done;
    } pcm_result_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [1:0]            kind;
        logic [15:0]           smp;
        logic [31:0]           meta;
        logic                  last;
        logic                  typed;
        pcm_result_t           want;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [1:0]                   kind;
    logic signed [SAMPLE_W-1:0]   sample;
    logic [META_W-1:0]            metadata;
    logic                         last;
    logic                         out_valid;
    logic                         out_stall;
    logic [1:0]                   result_kind;
    logic [SEQ_W-1:0]             sequence_res;
    logic                         accepted;
    logic [META_W-1:0]            block_metadata;
    logic signed [SAMPLE_W-1:0]   out_sample;
    logic                         run_end;
    logic [SEQ_W-1:0]             done_sequence;

    // ring model state
    logic [15:0]    store_mem [NSLOT*MAXS];
    bit             store_set [NSLOT*MAXS];
    logic [31:0]    slot_seq [NSLOT];
    logic [31:0]    slot_meta [NSLOT];
    bit             slot_set [NSLOT];
    logic [15:0]    stage [MAXS];
    int unsigned    wr_slot = 0;
    int unsigned    rd_slot = 0;
    int unsigned    occ = 0;
    int unsigned    push_cnt = 0;
    logic [31:0]    next_seq = '0;
    logic [31:0]    done_seq = '0;
    logic [4:0]     cap_reg = CAP_RESET;
    logic [6:0]     bs_reg = BS_RESET;

    pcm_result_t    step_results [$];
    pcm_result_t    due_results [$];
    stim_row_t      dir_rows [$];
    int             useful_items = 0;
    int             mismatches = 0;
    int             idle_cycles = 0;
    bit             tx_burst = 0;
    bit             rx_burst = 0;

    int phase_cap [NPHASE] = '{4, 16, 1, 31, 5, 3, 2, 16};
    int phase_bs [NPHASE] = '{3, 1, 5, 64, 127, 0, 4, 2};
    int phase_len [NPHASE] = '{30, 25, 20, 70, 15, 15, 25, 30};

    pcm_block_ring_queue u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .sample         (sample),
        .metadata       (metadata),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .sequence_res   (sequence_res),
        .accepted       (accepted),
        .block_metadata (block_metadata),
        .out_sample     (out_sample),
        .run_end        (run_end),
        .done_sequence  (done_sequence)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function int unsigned eff_cap();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > NSLOT)
            return NSLOT;
        return cap_reg;
    endfunction

    function int unsigned next_slot(input int unsigned s);
        return (s + 1 >= eff_cap()) ? 0 : s + 1;
    endfunction

    function int unsigned peek_len();
        if (bs_reg < 1)
            return 1;
        if (bs_reg > MAXS)
            return MAXS;
        return bs_reg;
    endfunction

    function pcm_result_t mk_result(input logic [1:0] rk, input logic [31:0] seq,
                                    input logic acc, input logic [31:0] meta,
                                    input logic [15:0] smp, input logic fin);
        pcm_result_t r;
        r.rkind = rk;
        r.seq = seq;
        r.acc = acc;
        r.meta = meta;
        r.smp = smp;
        r.fin = fin;
        r.done = done_seq;
        return r;
    endfunction

    // A peek must never read a slot or sample that was never written
    function bit peek_reads_written();
        int unsigned rs;
        if (occ == 0)
            return 1;
        rs = (rd_slot < NSLOT) ? rd_slot : 0;
        if (!slot_set[rs])
            return 0;
        for (int unsigned i = 0; i < peek_len(); i++)
            if (!store_set[rs*MAXS + i])
                return 0;
        return 1;
    endfunction

    // Advance the ring model by one accepted item and collect its results
    function void ring_step(input logic [1:0] k, input logic [15:0] s,
                            input logic [31:0] m, input logic l);
        int unsigned ws;
        int unsigned rs;
        logic [31:0] seq;
        bit ok;
        step_results.delete();
        case (k)
            KIND_PUSH:
            begin
                useful_items++;
                if (push_cnt < MAXS)
                    stage[push_cnt] = s;
                if (push_cnt < PUSH_COUNT_SAT)
                    push_cnt++;
                if (l)
                begin
                    seq = next_seq;
                    next_seq = next_seq + 1;
                    ok = bs_reg >= 1 && bs_reg <= MAXS && push_cnt == bs_reg
                         && occ < eff_cap();
                    if (ok)
                    begin
                        ws = (wr_slot < NSLOT) ? wr_slot : 0;
                        for (int unsigned i = 0; i < push_cnt; i++)
                        begin
                            store_mem[ws*MAXS + i] = stage[i];
                            store_set[ws*MAXS + i] = 1;
                        end
                        slot_seq[ws] = seq;
                        slot_meta[ws] = m;
                        slot_set[ws] = 1;
                        wr_slot = next_slot(ws);
                        occ++;
                    end
                    push_cnt = 0;
                    done_seq = seq + 1;
                    step_results.push_back(mk_result(RK_PUSH, seq, ok, '0, '0, 1'b1));
                end
            end
            KIND_PEEK:
            begin
                useful_items++;
                if (occ == 0)
                    step_results.push_back(mk_result(RK_EMPTY, '0, 1'b0, '0, '0, 1'b1));
                else
                begin
                    rs = (rd_slot < NSLOT) ? rd_slot : 0;
                    for (int unsigned i = 0; i < peek_len(); i++)
                        step_results.push_back(mk_result(RK_SAMPLE, slot_seq[rs], 1'b0,
                            slot_meta[rs], store_mem[rs*MAXS + i], i + 1 == peek_len()));
                end
            end
            KIND_POP:
            begin
                if (occ != 0)
                begin
                    useful_items++;
                    rd_slot = next_slot(rd_slot);
                    occ--;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        dir_rows.push_back(r);
    endfunction

    function void add_item(input logic [1:0] k, input logic [15:0] s,
                           input logic [31:0] m, input logic l);
        stim_row_t r;
        r = '0;
        r.kind = k;
        r.smp = s;
        r.meta = m;
        r.last = l;
        dir_rows.push_back(r);
    endfunction

    // Row whose single result is typed in: push status or empty peek
    function void add_check(input logic [1:0] k, input logic [15:0] s, input logic [31:0] m,
                            input logic l, input logic [1:0] rk, input logic [31:0] seq,
                            input logic acc, input logic [31:0] done);
        stim_row_t r;
        r = '0;
        r.kind = k;
        r.smp = s;
        r.meta = m;
        r.last = l;
        r.typed = 1'b1;
        r.want.rkind = rk;
        r.want.seq = seq;
        r.want.acc = acc;
        r.want.fin = 1'b1;
        r.want.done = done;
        dir_rows.push_back(r);
    endfunction

    function string fmt_result(input pcm_result_t r);
        return $sformatf("kind=%0d seq=%h acc=%0d meta=%h smp=%h end=%0d done=%h",
                         r.rkind, r.seq, r.acc, r.meta, r.smp, r.fin, r.done);
    endfunction

    // Drive one item, hold it until taken, then book its expected results
    task automatic send_item(input stim_row_t r);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= r.kind;
        sample <= r.smp;
        metadata <= r.meta;
        last <= r.last;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        ring_step(r.kind, r.smp, r.meta, r.last);
        if (r.typed)
            due_results.push_back(r.want);
        else
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
        @(posedge clk);
    endtask

    task automatic send_plain(input logic [1:0] k, input logic l);
        stim_row_t r;
        r = '0;
        r.kind = k;
        r.smp = $urandom_range(0, 65535);
        r.meta = $urandom;
        r.last = l;
        send_item(r);
    endtask

    task automatic push_block(input int len);
        for (int i = 0; i < len; i++)
            send_plain(KIND_PUSH, i == len - 1);
    endtask

    // Hold the sender until every expected result has come
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (COPY_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        if (idx == CFG_CAPACITY)
            cap_reg = val[4:0];
        else if (idx == CFG_BLOCK_SAMPLES)
            bs_reg = val;
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int cap, input int bs, input int target);
        int goal;
        int pick;
        int len;
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_BLOCK_SAMPLES, bs);
        goal = useful_items + target;
        while (useful_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 24) == 0)
                wait_drained();
            if (pick < 50)
                push_block((bs >= 1 && bs <= MAXS) ? bs : $urandom_range(1, 6));
            else if (pick < 56)
            begin
                len = $urandom_range(1, 8);
                push_block((len == bs) ? len + 1 : len);
            end
            else if (pick < 58)
                push_block($urandom_range(MAXS + 1, 140));
            else if (pick < 80)
                send_plain(peek_reads_written() ? KIND_PEEK : KIND_POP, $urandom_range(0, 1));
            else if (pick < 95)
                send_plain(KIND_POP, $urandom_range(0, 1));
            else
                send_plain(KIND_UNUSED, $urandom_range(0, 1));
        end
    endtask

    // Result side: take results with random stalls and compare in order
    initial
    begin
        int hold;
        bit took;
        pcm_result_t want;
        pcm_result_t got;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            took = out_valid && !out_stall;
            if (took)
            begin
                got.rkind = result_kind;
                got.seq = sequence_res;
                got.acc = accepted;
                got.meta = block_metadata;
                got.smp = out_sample;
                got.fin = run_end;
                got.done = done_sequence;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %s", fmt_result(got));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.rkind !== got.rkind || want.seq !== got.seq
                        || want.acc !== got.acc || want.meta !== got.meta
                        || want.smp !== got.smp || want.fin !== got.fin
                        || want.done !== got.done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %s\n          got      %s",
                                     fmt_result(want), fmt_result(got));
                    end
                end
            end
            @(posedge clk);
            if (took)
            begin
                hold = rx_burst ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 19) == 0)
                    rx_burst = !rx_burst;
            end
            out_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("pcm_block_ring_queue regression: fail");
        $finish;
    end

    // Stimulus
    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        kind <= KIND_PUSH;
        sample <= '0;
        metadata <= '0;
        last <= 1'b0;

        // Directed table
        add_check(KIND_PEEK, 16'h0000, 32'h0, 1'b0, RK_EMPTY, 32'd0, 1'b0, 32'd0);
        add_item(KIND_POP, 16'h1234, 32'h0, 1'b0);
        add_item(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        add_check(KIND_PUSH, 16'h0001, 32'h0, 1'b1, RK_PUSH, 32'd0, 1'b0, 32'd1);
        add_cfg(CFG_CAPACITY, 7'd2);
        add_cfg(CFG_BLOCK_SAMPLES, 7'd2);
        add_item(KIND_PUSH, 16'h8000, 32'h0, 1'b0);
        add_check(KIND_PUSH, 16'h7FFF, 32'hFFFF_FFFF, 1'b1, RK_PUSH, 32'd1, 1'b1, 32'd2);
        add_item(KIND_PUSH, 16'h0000, 32'h0, 1'b0);
        add_check(KIND_PUSH, 16'hFFFF, 32'h0, 1'b1, RK_PUSH, 32'd2, 1'b1, 32'd3);
        // wrong size, then full
        add_item(KIND_PUSH, 16'hA5A5, 32'h0, 1'b0);
        add_item(KIND_PUSH, 16'h5A5A, 32'h0, 1'b0);
        add_check(KIND_PUSH, 16'h1234, 32'hDEAD_BEEF, 1'b1, RK_PUSH, 32'd3, 1'b0, 32'd4);
        add_item(KIND_PUSH, 16'h0001, 32'h0, 1'b0);
        add_check(KIND_PUSH, 16'h0002, 32'h1, 1'b1, RK_PUSH, 32'd4, 1'b0, 32'd5);
        add_item(KIND_PEEK, 16'h0000, 32'h0, 1'b0);
        add_item(KIND_POP, 16'h0000, 32'h0, 1'b0);
        add_item(KIND_PEEK, 16'h0000, 32'h0, 1'b1);
        add_item(KIND_POP, 16'h0000, 32'h0, 1'b0);
        add_item(KIND_POP, 16'h0000, 32'h0, 1'b0);
        add_check(KIND_PEEK, 16'h0000, 32'h0, 1'b0, RK_EMPTY, 32'd0, 1'b0, 32'd5);
        // capacity 0 acts as one slot
        add_cfg(CFG_CAPACITY, 7'd0);
        add_cfg(CFG_BLOCK_SAMPLES, 7'd1);
        add_check(KIND_PUSH, 16'h4321, 32'h55AA_55AA, 1'b1, RK_PUSH, 32'd5, 1'b1, 32'd6);
        add_check(KIND_PUSH, 16'h0000, 32'h0, 1'b1, RK_PUSH, 32'd6, 1'b0, 32'd7);
        // block size 0 rejects pushes and peeks one sample
        add_cfg(CFG_BLOCK_SAMPLES, 7'd0);
        add_item(KIND_PEEK, 16'h0000, 32'h0, 1'b0);
        add_check(KIND_PUSH, 16'h0007, 32'h0, 1'b1, RK_PUSH, 32'd7, 1'b0, 32'd8);
        add_item(KIND_POP, 16'h0000, 32'h0, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            else
                send_item(dir_rows[i]);
        end

        // Random phases across register settings
        for (int p = 0; p < NPHASE; p++)
            run_phase(phase_cap[p], phase_bs[p], phase_len[p]);

        wait_drained();
        repeat (COPY_SETTLE) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("pcm_block_ring_queue regression: pass");
        else
            $display("pcm_block_ring_queue regression: fail");
        $finish;
    end

endmodule

[files.f]
hw/rtl/pbrq_pkg.sv
hw/rtl/pcm_block_ring_queue.sv
dv/pcm_block_ring_queue_test.sv
